### hdl/positional_list_table_defines.svh
// ----------------------------------------------------------------------------
// Positional list table assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_TABLE_DEFINES_SVH
`define POSITIONAL_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define PLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/plt_pkg.sv
// ----------------------------------------------------------------------------
// Positional list table package
// Opcodes, status codes, controller states and the cell command bundle.
// ----------------------------------------------------------------------------
package plt_pkg;

  // Width of position-like values broadcast to the cells (covers 4096 slots).
  localparam int PW = 12;

  // Match bits examined per scan cycle.
  localparam int SCAN_LANE = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOCATE = 2'd3
  } plt_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } plt_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } plt_state_t;

  typedef struct packed {
    logic          ins;   // insert at slot, cells above slot take the left neighbor
    logic          del;   // delete at slot, cells from slot take the right neighbor
    logic [PW-1:0] slot;  // zero-based position of the operation
    logic [PW-1:0] tail;  // index of the last live entry
    logic [PW-1:0] fill;  // number of live entries
  } plt_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } plt_scan_sts_t;

endpackage

### hdl/plt_cell.sv
// ----------------------------------------------------------------------------
// Positional list table storage cell
// Holds one entry, shifts with its neighbors and flags a value match.
// ----------------------------------------------------------------------------
module plt_cell #(
  parameter int VW  = 32,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  plt_pkg::plt_cmd_t cmd,
  input  logic [VW-1:0]     vnew,
  input  logic [VW-1:0]     left_d,
  input  logic [VW-1:0]     right_d,
  output logic [VW-1:0]     data_q,
  output logic              match
);

  localparam logic [plt_pkg::PW-1:0] MY_IDX = plt_pkg::PW'(IDX);

  logic [VW-1:0] data_r;
  logic [VW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    priority if (cmd.ins && (MY_IDX > cmd.slot)) begin
      data_nxt = left_d;
    end else if (cmd.ins && (MY_IDX == cmd.slot)) begin
      data_nxt = vnew;
    end else if (cmd.del && (MY_IDX >= cmd.slot) && (MY_IDX < cmd.tail)) begin
      data_nxt = right_d;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Entries at or beyond the fill level are stale and never match.
  assign match  = (data_r == vnew) && (MY_IDX < cmd.fill);
  assign data_q = data_r;

endmodule

### hdl/plt_scan.sv
// ----------------------------------------------------------------------------
// Positional list table match scanner
// Walks the captured match vector one lane of bits per cycle, lowest first.
// ----------------------------------------------------------------------------
module plt_scan #(
  parameter int CAPACITY = 64,
  parameter int IW       = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [CAPACITY-1:0]         match_in,
  output plt_pkg::plt_scan_sts_t      sts,
  output logic [IW-1:0]               hit_idx
);

  localparam int LANE = plt_pkg::SCAN_LANE;
  localparam int NCH  = (CAPACITY + LANE - 1) / LANE;
  localparam int MW   = NCH * LANE;
  localparam int LW   = $clog2(LANE);

  logic [MW-1:0]   mvec_r;
  logic [MW-1:0]   mvec_nxt;
  logic [IW-1:0]   base_r;
  logic [IW-1:0]   base_nxt;
  logic [LANE-1:0] chunk;
  logic [LW-1:0]   enc;

  assign chunk = mvec_r[LANE-1:0];

  // Lowest set bit of the current lane.
  always_comb begin
    enc = '0;
    for (int i = LANE - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        enc = LW'(i);
      end
    end
  end

  assign sts.hit  = |chunk;
  assign sts.done = sts.hit || (mvec_r == '0);
  assign hit_idx  = base_r + IW'(enc);

  always_comb begin
    mvec_nxt = mvec_r;
    base_nxt = base_r;
    if (load) begin
      mvec_nxt = MW'(match_in);
      base_nxt = '0;
    end else if (!sts.done) begin
      mvec_nxt = mvec_r >> LANE;
      base_nxt = base_r + IW'(LANE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvec_r <= '0;
      base_r <= '0;
    end else begin
      mvec_r <= mvec_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

### hdl/positional_list_table.sv
// ----------------------------------------------------------------------------
// Positional list table
// Ordered list of signed values at 1-based positions, kept in a row of cells.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | tdata                                   | tuser
//   in_     | slave     | [6:0] position, [38:7] value, pad to 40 | [1:0] opcode
//   out_    | master    | [6:0] found_position, [13:7] list_length| [1:0] status
//
// Clear, insert and delete take effect at the clock edge that accepts their beat, since
// every cell shifts with its neighbor at once. Locate compares the value in all cells
// as its beat is accepted, then the match scanner walks the match vector eight cells a cycle.
// Reset empties the list; cell contents are not cleared.
// A new input beat is taken only while no locate is scanning and the output
// register is empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module positional_list_table #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] found_position, [13:7] list_length, [15:14] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  `include "positional_list_table_defines.svh"

  localparam int VW   = VALUE_WIDTH;
  localparam int PW   = plt_pkg::PW;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int LANE = plt_pkg::SCAN_LANE;
  localparam int MW   = ((CAPACITY + LANE - 1) / LANE) * LANE;
  localparam int IW   = $clog2(MW);
  localparam int FW   = IW + 1;

  // Input beat fields.
  plt_pkg::plt_op_t  in_op;
  logic [6:0]        in_position;
  logic [31:0]       in_value;
  logic [VW+31:0]    vwide;
  logic [VW-1:0]     vnew;

  assign in_op       = plt_pkg::plt_op_t'(in_tuser);
  assign in_position = in_tdata[6:0];
  assign in_value    = in_tdata[38:7];
  assign vwide       = {{VW{1'b0}}, in_value};
  assign vnew        = vwide[VW-1:0];

  // Control state.
  plt_pkg::plt_state_t  state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  plt_pkg::plt_status_t out_status_r, out_status_nxt;
  logic [6:0]           out_found_r, out_found_nxt;
  logic [6:0]           out_len_r, out_len_nxt;

  logic                 acc;
  logic                 out_free;
  logic                 scan_load;
  logic                 ins_ok;
  logic [PW-1:0]        cnt_w;
  logic [PW-1:0]        pos_w;
  logic                 is_full;
  logic                 ins_bad;
  logic                 del_bad;
  plt_pkg::plt_cmd_t    cmd;
  plt_pkg::plt_scan_sts_t scan_sts;
  logic [IW-1:0]        hit_idx;
  logic [FW-1:0]        hit_pos;

  logic [CAPACITY-1:0]  match_vec;
  logic [VW-1:0]        cell_q [CAPACITY];

  assign cnt_w    = PW'(count_r);
  assign pos_w    = PW'(in_position);
  assign is_full  = (cnt_w == PW'(CAPACITY));
  assign ins_bad  = (in_position == 7'd0) || (pos_w > (cnt_w + PW'(1)));
  assign del_bad  = (in_position == 7'd0) || (pos_w > cnt_w);
  assign out_free = !out_valid_r || out_tready;
  assign acc      = in_tvalid && in_tready;
  assign hit_pos  = FW'(hit_idx) + FW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;
    in_tready      = 1'b0;
    scan_load      = 1'b0;
    ins_ok         = 1'b0;
    cmd.ins        = 1'b0;
    cmd.del        = 1'b0;
    cmd.slot       = pos_w - PW'(1);
    cmd.tail       = cnt_w - PW'(1);
    cmd.fill       = cnt_w;
    unique case (state_r)
      plt_pkg::S_IDLE: begin
        in_tready = out_free;
        if (acc) begin
          out_found_nxt = 7'd0;
          unique case (in_op)
            plt_pkg::OP_CLEAR: begin
              count_nxt      = '0;
              out_status_nxt = plt_pkg::ST_OK;
            end
            plt_pkg::OP_INSERT: begin
              if (is_full) begin
                out_status_nxt = plt_pkg::ST_FULL;
              end else if (ins_bad) begin
                out_status_nxt = plt_pkg::ST_BADPOS;
              end else begin
                ins_ok         = 1'b1;
                cmd.ins        = 1'b1;
                count_nxt      = count_r + CW'(1);
                out_status_nxt = plt_pkg::ST_OK;
              end
            end
            plt_pkg::OP_DELETE: begin
              if (del_bad) begin
                out_status_nxt = plt_pkg::ST_BADPOS;
              end else begin
                cmd.del        = 1'b1;
                count_nxt      = count_r - CW'(1);
                out_status_nxt = plt_pkg::ST_OK;
              end
            end
            plt_pkg::OP_LOCATE: begin
              scan_load = 1'b1;
              state_nxt = plt_pkg::S_SCAN;
            end
            default: begin
              out_status_nxt = plt_pkg::ST_OK;
            end
          endcase
          if (in_op != plt_pkg::OP_LOCATE) begin
            out_valid_nxt = 1'b1;
            out_len_nxt   = 7'(count_nxt);
          end
        end
      end
      plt_pkg::S_SCAN: begin
        if (scan_sts.done && out_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = 7'(count_r);
          if (scan_sts.hit) begin
            out_status_nxt = plt_pkg::ST_OK;
            out_found_nxt  = 7'(hit_pos);
          end else begin
            out_status_nxt = plt_pkg::ST_NOTFOUND;
            out_found_nxt  = 7'd0;
          end
          state_nxt = plt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
  end

  // Row of storage cells; each one sees its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_d;
    logic [VW-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end

    plt_cell #(
      .VW  (VW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .vnew    (vnew),
      .left_d  (left_d),
      .right_d (right_d),
      .data_q  (cell_q[i]),
      .match   (match_vec[i])
    );
  end

  plt_scan #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (scan_load),
    .match_in (match_vec),
    .sts      (scan_sts),
    .hit_idx  (hit_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_found_r};
  assign out_tuser  = out_status_r;

  `PLT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "list length above capacity")
  `PLT_ASSERT_NEXT(a_insert_grows, ins_ok, count_r == $past(count_r) + CW'(1), "insert did not grow list")
  `PLT_ASSERT_NEXT(a_scan_holds_count, state_r == plt_pkg::S_SCAN, count_r == $past(count_r), "list length changed during locate")

endmodule

### tb/sv/positional_list_table_tb.sv
// ----------------------------------------------------------------------------
// Positional list table testbench
// Drives insert, delete, locate and clear beats into the list table and checks
// every result beat against a behavioral copy of the list kept in the bench.
// ----------------------------------------------------------------------------
module positional_list_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP       = 64;
  localparam int DRAIN_CYC = 16;   // locate scan plus output register, with margin
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    plt_pkg::plt_status_t status;
    logic [6:0]           found;
    logic [6:0]           length;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shadow copy of the list.
  logic [31:0]  list_vals [CAP];
  int           list_len;
  list_result_t pending_results [$];

  int idle_pct;
  int stall_pct;
  int hold_left;
  int mismatches;
  int results_seen;
  int in_stall_cycles;
  int op_seen [4];
  int status_seen [4];

  positional_list_table #(
    .CAPACITY   (CAP),
    .VALUE_WIDTH(32)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results still expected", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // Applies one operation to the shadow list and returns the result it gives.
  function automatic list_result_t apply_list_op(plt_pkg::plt_op_t op, logic [6:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int k;
    bit hit;
    r.status = plt_pkg::ST_OK;
    r.found  = '0;
    hit      = 1'b0;
    case (op)
      plt_pkg::OP_CLEAR: begin
        list_len = 0;
      end
      plt_pkg::OP_INSERT: begin
        if (list_len >= CAP) begin
          r.status = plt_pkg::ST_FULL;
        end else if (pos < 1 || pos > list_len + 1) begin
          r.status = plt_pkg::ST_BADPOS;
        end else begin
          for (k = list_len; k >= pos; k--) list_vals[k] = list_vals[k-1];
          list_vals[pos-1] = val;
          list_len++;
        end
      end
      plt_pkg::OP_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          r.status = plt_pkg::ST_BADPOS;
        end else begin
          for (k = pos; k < list_len; k++) list_vals[k-1] = list_vals[k];
          list_len--;
        end
      end
      default: begin
        r.status = plt_pkg::ST_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (!hit && list_vals[k] == val) begin
            hit      = 1'b1;
            r.status = plt_pkg::ST_OK;
            r.found  = 7'(k + 1);
          end
        end
      end
    endcase
    r.length = 7'(list_len);
    return r;
  endfunction

  // Offers one beat after a random gap and records its result once accepted.
  // Valid is left high so back-to-back beats never toggle it within one step.
  task automatic send_op(plt_pkg::plt_op_t op, logic [6:0] pos, logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, val));
    op_seen[op]++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed operations; the list drifts toward the target length.
  task automatic send_random_op(int target_len);
    int               pick;
    plt_pkg::plt_op_t op;
    logic [6:0]       pos;
    logic [31:0]      val;
    pick = $urandom_range(99);
    if (pick < 1)
      op = plt_pkg::OP_CLEAR;
    else if (list_len < target_len)
      op = (pick < 60) ? plt_pkg::OP_INSERT :
           (pick < 76) ? plt_pkg::OP_DELETE : plt_pkg::OP_LOCATE;
    else
      op = (pick < 30) ? plt_pkg::OP_INSERT :
           (pick < 70) ? plt_pkg::OP_DELETE : plt_pkg::OP_LOCATE;

    pos = 7'($urandom_range(127));
    if ($urandom_range(99) < 85) begin
      if (op == plt_pkg::OP_INSERT)
        pos = 7'($urandom_range(list_len + 1, 1));
      else if (op == plt_pkg::OP_DELETE && list_len > 0)
        pos = 7'($urandom_range(list_len, 1));
    end

    val = $urandom;
    if (op == plt_pkg::OP_LOCATE && list_len > 0 && $urandom_range(99) < 60)
      val = list_vals[$urandom_range(list_len - 1)];
    else if ($urandom_range(99) < 30)
      val = 32'($signed($urandom_range(4)) - 2);  // small pool gives duplicates
    send_op(op, pos, val);
  endtask

  task automatic test_empty_list_edges();
    send_op(plt_pkg::OP_LOCATE, 7'd0,   32'd0);
    send_op(plt_pkg::OP_DELETE, 7'd1,   32'd0);
    send_op(plt_pkg::OP_INSERT, 7'd0,   32'd5);
    send_op(plt_pkg::OP_INSERT, 7'd2,   32'd5);
    send_op(plt_pkg::OP_INSERT, 7'd1,   32'h7FFF_FFFF);
    send_op(plt_pkg::OP_INSERT, 7'd1,   32'h8000_0000);
    send_op(plt_pkg::OP_INSERT, 7'd3,   32'h0000_0000);
    send_op(plt_pkg::OP_INSERT, 7'd2,   32'hFFFF_FFFF);
    send_op(plt_pkg::OP_LOCATE, 7'd127, 32'h8000_0000);
    send_op(plt_pkg::OP_LOCATE, 7'd0,   32'h7FFF_FFFF);
    send_op(plt_pkg::OP_LOCATE, 7'd0,   32'd12345);
    send_op(plt_pkg::OP_DELETE, 7'd4,   32'd0);
    send_op(plt_pkg::OP_DELETE, 7'd4,   32'd0);
    send_op(plt_pkg::OP_DELETE, 7'd127, 32'd0);
    send_op(plt_pkg::OP_INSERT, 7'd127, 32'd1);
    send_op(plt_pkg::OP_DELETE, 7'd0,   32'd0);
    send_op(plt_pkg::OP_CLEAR,  7'd127, 32'hFFFF_FFFF);
    // Entries survive a clear, but none of them may be found again.
    send_op(plt_pkg::OP_LOCATE, 7'd0,   32'h0000_0000);
    send_op(plt_pkg::OP_DELETE, 7'd1,   32'd0);
    send_op(plt_pkg::OP_INSERT, 7'd1,   32'h5555_AAAA);
  endtask

  task automatic test_fill_to_capacity();
    int i;
    logic [6:0] pos;
    send_op(plt_pkg::OP_CLEAR, 7'd0, 32'd0);
    for (i = 0; i < CAP; i++) begin
      pos = (i % 3 == 0) ? 7'd1 : (i % 3 == 1) ? 7'(i + 1) : 7'(i / 2 + 1);
      send_op(plt_pkg::OP_INSERT, pos,
              (i == 40) ? 32'd7 : (i == 9) ? 32'd7 : 32'(i * 32'h0101_0101));
    end
    send_op(plt_pkg::OP_INSERT, 7'd65, 32'd1);
    send_op(plt_pkg::OP_INSERT, 7'd0,  32'd1);
    send_op(plt_pkg::OP_LOCATE, 7'd0,  list_vals[CAP-1]);
    send_op(plt_pkg::OP_LOCATE, 7'd0,  32'd7);
    send_op(plt_pkg::OP_DELETE, 7'd64, 32'd0);
    send_op(plt_pkg::OP_DELETE, 7'd1,  32'd0);
    send_op(plt_pkg::OP_DELETE, 7'd63, 32'd0);
    send_op(plt_pkg::OP_LOCATE, 7'd0,  32'hDEAD_BEEF);
  endtask

  task automatic random_phase(int n, int idle, int stall, int target_len);
    int i;
    idle_pct  = idle;
    stall_pct = stall;
    for (i = 0; i < n; i++) send_random_op(target_len);
  endtask

  task automatic test_random_traffic();
    random_phase(130, 0,  0,  64);
    random_phase(130, 62, 0,  8);
    random_phase(130, 0,  62, 64);
    random_phase(130, 29, 29, 30);
  endtask

  // The receiver holds off while the sender keeps offering, so the output
  // register fills and the input channel must stall.
  task automatic test_output_backpressure();
    int i;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 150;
    for (i = 0; i < 40; i++) send_random_op(64);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && in_tvalid && !in_tready) in_stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      status_seen[out_tuser]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("Unexpected result beat: status %0d found %0d length %0d",
                   out_tuser, out_tdata[6:0], out_tdata[13:7]);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status || out_tdata[6:0] !== want.found ||
            out_tdata[13:7] !== want.length) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("Result %0d: expected status %0d found %0d length %0d, got %0d %0d %0d",
                     results_seen, want.status, want.found, want.length,
                     out_tuser, out_tdata[6:0], out_tdata[13:7]);
        end
      end
    end
  end

  initial begin
    list_len        = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_left       = 0;
    mismatches      = 0;
    results_seen    = 0;
    in_stall_cycles = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (list_vals[i]) list_vals[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list_edges();
    test_fill_to_capacity();
    test_random_traffic();
    test_output_backpressure();

    drain_results();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Checked %0d results: %0d clear, %0d insert, %0d delete, %0d locate beats",
             results_seen, op_seen[plt_pkg::OP_CLEAR], op_seen[plt_pkg::OP_INSERT],
             op_seen[plt_pkg::OP_DELETE], op_seen[plt_pkg::OP_LOCATE]);
    $display("Status ok %0d, full %0d, bad position %0d, not found %0d, input stalls %0d",
             status_seen[plt_pkg::ST_OK], status_seen[plt_pkg::ST_FULL],
             status_seen[plt_pkg::ST_BADPOS], status_seen[plt_pkg::ST_NOTFOUND],
             in_stall_cycles);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
